FILE: design/cmrt_pkg.sv
// Shared widths, configuration codes and the multiply-accumulate control
// and result types of the Catmull-Rom curve tessellator. No dependencies.
package cmrt_pkg;

	// Coordinate and parameter widths.
	localparam int COORD_W = 32;
	localparam int SEG_W   = 6;
	localparam int T_W     = 17;
	localparam int CNT_W   = $clog2(T_W);
	localparam int T2_W    = 33;
	localparam int T3_W    = 49;

	// Shared multiplier operand and product widths.
	localparam int MA_W    = 34;
	localparam int MB_W    = 26;
	localparam int PROD_W  = MA_W + MB_W;

	// Parameter t runs from zero to this value (1.0 in Q1.16).
	localparam logic [T_W-1:0] T_ONE = 17'h10000;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS = 2'd1;
	localparam logic [SEG_W-1:0]     SEG_RESET    = 6'd8;

	// Control travelling with each product through the multiply stage.
	typedef struct packed {
		logic       vld;
		logic       first;
		logic       last;
		logic [1:0] idx;
	} mac_ctl_t;

	// Finished coordinate from the accumulator.
	typedef struct packed {
		logic                      vld;
		logic [1:0]                idx;
		logic signed [COORD_W-1:0] coord;
	} mac_res_t;

endpackage

FILE: design/catmull_rom_curve_tessellator_core.sv
// Catmull-Rom curve tessellator: a point that only fills the window is just stored.
// A point that completes a span starts the divider, which produces the 17 quotient
// bits, then each of the n+1 curve points uses the one shared multiplier for t^2,
// t^3 and twelve weight products; an output stall holds the sequencer in its last step.
// Asynchronous active-low reset empties the window, drops any pending result and
// restores smooth mode with eight segments.
module catmull_rom_curve_tessellator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cmrt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cmrt_pkg::SEG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [cmrt_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [cmrt_pkg::COORD_W-1:0]  pos_y,
	input  logic signed [cmrt_pkg::COORD_W-1:0]  pos_z,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [cmrt_pkg::COORD_W-1:0]  curve_x,
	output logic signed [cmrt_pkg::COORD_W-1:0]  curve_y,
	output logic signed [cmrt_pkg::COORD_W-1:0]  curve_z,
	output logic                                 span_end
);
	import cmrt_pkg::*;

	localparam int WS_W = 53;
	localparam logic signed [WS_W-1:0] BASIS_ONE = 53'sh2000000000000;
	localparam logic signed [WS_W-1:0] RND_W     = 53'sh1000000;
	localparam logic [24:0]            W_ONE     = 25'h1000000;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_DIV   = 8'b00000010,
		ST_SQR   = 8'b00000100,
		ST_CUB   = 8'b00001000,
		ST_WGT   = 8'b00010000,
		ST_MAC   = 8'b00100000,
		ST_DRAIN = 8'b01000000,
		ST_PUT   = 8'b10000000
	} state_t;

	state_t                    state_q;
	logic                      smooth_q;
	logic [SEG_W-1:0]          seg_q;
	logic [1:0]                fill_q;
	logic signed [COORD_W-1:0] win_q [3][3];
	logic signed [COORD_W-1:0] new_q [3];
	logic signed [COORD_W-1:0] pos_in [3];
	logic [SEG_W-1:0]          n_q;
	logic [SEG_W-1:0]          i_q;
	logic [T_W-1:0]            t_q;
	logic [SEG_W-1:0]          r_q;
	logic [T_W-1:0]            qstep_q;
	logic [SEG_W-1:0]          rstep_q;
	logic [T2_W-1:0]           t2_q;
	logic signed [MB_W-1:0]    w_q [4];
	logic signed [MB_W-1:0]    w_d [4];
	logic [1:0]                c_q;
	logic [1:0]                k_q;
	logic signed [COORD_W-1:0] res_q [3];
	logic                      out_valid_q;
	logic signed [COORD_W-1:0] out_x_q;
	logic signed [COORD_W-1:0] out_y_q;
	logic signed [COORD_W-1:0] out_z_q;
	logic                      out_end_q;

	logic                      in_acc;
	logic                      span_go;
	logic [SEG_W-1:0]          seg_eff;
	logic [1:0]                wr_slot;
	logic                      put_go;
	logic                      span_last;
	logic [SEG_W:0]            r_sum;
	logic                      r_wrap;
	logic                      div_done;
	logic [T_W-1:0]            div_quo;
	logic [SEG_W-1:0]          div_rem;
	mac_ctl_t                  mac_ctl;
	mac_res_t                  mac_res;
	logic signed [MA_W-1:0]    op_a;
	logic signed [MB_W-1:0]    op_b;
	logic signed [PROD_W-1:0]  prod;
	logic signed [COORD_W-1:0] p_sel;
	logic signed [WS_W-1:0]    big_t1;
	logic signed [WS_W-1:0]    big_t2;
	logic signed [WS_W-1:0]    big_t3;
	logic signed [WS_W-1:0]    tw [4];

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	// Handshake decodes.
	assign cfg_ready = 1'b1;
	assign in_ready  = state_q == ST_IDLE;
	assign in_acc    = in_valid & in_ready;
	assign span_go   = in_acc & ~restart & (fill_q == 2'd3);
	assign seg_eff   = (seg_q == '0) ? SEG_W'(1) : seg_q;
	assign wr_slot   = restart ? 2'd0 : fill_q;
	assign put_go    = (state_q == ST_PUT) & (~out_valid_q | out_ready);
	assign span_last = i_q == n_q;

	// Next t: add the quotient step and carry the remainder past n.
	always_comb begin
		r_sum  = {1'b0, r_q} + {1'b0, rstep_q};
		r_wrap = r_sum >= {1'b0, n_q};
	end

	cmrt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (span_go),
		.divisor (seg_eff),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	// Control point picked for the current product.
	always_comb begin
		p_sel = '0;
		for (int c = 0; c < 3; c++) begin
			if (c_q == 2'(c)) begin
				if (k_q == 2'd3) begin
					p_sel = new_q[c];
				end else begin
					for (int k = 0; k < 3; k++) begin
						if (k_q == 2'(k)) begin
							p_sel = win_q[k][c];
						end
					end
				end
			end
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		op_a          = '0;
		op_b          = '0;
		mac_ctl       = '0;
		mac_ctl.first = k_q == 2'd0;
		mac_ctl.last  = k_q == 2'd3;
		mac_ctl.idx   = c_q;
		case (state_q)
			ST_SQR: begin
				op_a = $signed(MA_W'(t_q));
				op_b = $signed(MB_W'(t_q));
			end
			ST_CUB: begin
				op_a = $signed(MA_W'(prod[T2_W-1:0]));
				op_b = $signed(MB_W'(t_q));
			end
			ST_MAC: begin
				op_a        = MA_W'(p_sel);
				op_b        = w_q[k_q];
				mac_ctl.vld = 1'b1;
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	cmrt_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod   (prod),
		.res    (mac_res)
	);

	// Basis weights from t, t^2 and t^3, rounded to Q.24.
	always_comb begin
		big_t1 = $signed(WS_W'({t_q, 32'd0}));
		big_t2 = $signed(WS_W'({t2_q, 16'd0}));
		big_t3 = $signed(WS_W'(prod[T3_W-1:0]));
		tw[0]  = (big_t2 <<< 1) - big_t3 - big_t1;
		tw[1]  = big_t3 + (big_t3 <<< 1) - (big_t2 <<< 2) - big_t2 + BASIS_ONE;
		tw[2]  = (big_t2 <<< 2) + big_t1 - big_t3 - (big_t3 <<< 1);
		tw[3]  = big_t3 - big_t2;
		if (smooth_q) begin
			for (int k = 0; k < 4; k++) begin
				w_d[k] = MB_W'((tw[k] + RND_W) >>> 25);
			end
		end else begin
			w_d[0] = '0;
			w_d[1] = $signed(MB_W'(W_ONE - {t_q, 8'd0}));
			w_d[2] = $signed(MB_W'({t_q, 8'd0}));
			w_d[3] = '0;
		end
	end

	// Sequencer, configuration registers and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			smooth_q    <= 1'b1;
			seg_q       <= SEG_RESET;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			c_q         <= '0;
			k_q         <= '0;
			i_q         <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SMOOTH:   smooth_q <= cfg_data[0];
					CFG_SEGMENTS: seg_q    <= cfg_data;
					default:      seg_q    <= seg_q;
				endcase
			end
			if (in_acc) begin
				if (restart) begin
					fill_q <= 2'd1;
				end else if (fill_q != 2'd3) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (put_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (span_go) begin
						state_q <= ST_DIV;
						i_q     <= '0;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					state_q <= ST_CUB;
				end
				ST_CUB: begin
					state_q <= ST_WGT;
				end
				ST_WGT: begin
					state_q <= ST_MAC;
					c_q     <= '0;
					k_q     <= '0;
				end
				ST_MAC: begin
					if (k_q == 2'd3) begin
						k_q <= '0;
						c_q <= c_q + 1'b1;
						if (c_q == 2'd2) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (put_go) begin
						if (span_last) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_SQR;
							i_q     <= i_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window, step values, weights and results.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int c = 0; c < 3; c++) begin
				new_q[c] <= pos_in[c];
				for (int s = 0; s < 3; s++) begin
					if (fill_q != 2'd3 || restart) begin
						if (wr_slot == 2'(s)) begin
							win_q[s][c] <= pos_in[c];
						end
					end
				end
			end
		end
		if (span_go) begin
			n_q <= seg_eff;
		end
		if (state_q == ST_DIV && div_done) begin
			qstep_q <= div_quo;
			rstep_q <= div_rem;
			t_q     <= '0;
			r_q     <= n_q >> 1;
		end
		if (state_q == ST_CUB) begin
			t2_q <= prod[T2_W-1:0];
		end
		if (state_q == ST_WGT) begin
			for (int k = 0; k < 4; k++) begin
				w_q[k] <= w_d[k];
			end
		end
		if (mac_res.vld) begin
			for (int c = 0; c < 3; c++) begin
				if (mac_res.idx == 2'(c)) begin
					res_q[c] <= mac_res.coord;
				end
			end
		end
		if (put_go) begin
			out_x_q   <= res_q[0];
			out_y_q   <= res_q[1];
			out_z_q   <= res_q[2];
			out_end_q <= span_last;
			if (span_last) begin
				// Slide the window by one point.
				for (int c = 0; c < 3; c++) begin
					win_q[0][c] <= win_q[1][c];
					win_q[1][c] <= win_q[2][c];
					win_q[2][c] <= new_q[c];
				end
			end else begin
				if (r_wrap) begin
					r_q <= SEG_W'(r_sum - {1'b0, n_q});
					t_q <= t_q + qstep_q + 1'b1;
				end else begin
					r_q <= r_sum[SEG_W-1:0];
					t_q <= t_q + qstep_q;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign curve_x   = out_x_q;
	assign curve_y   = out_y_q;
	assign curve_z   = out_z_q;
	assign span_end  = out_end_q;

endmodule

FILE: design/cmrt_div.sv
// Bit-serial restoring divider that splits 1.0 (Q1.16) by the segment count
// into the per-step quotient and remainder. Depends on cmrt_pkg.
module cmrt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cmrt_pkg::SEG_W-1:0] divisor,
	output logic                       done,
	output logic [cmrt_pkg::T_W-1:0]   quo,
	output logic [cmrt_pkg::SEG_W-1:0] rem
);
	import cmrt_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SEG_W-1:0] dvs_q;
	logic [SEG_W-1:0] rem_q;
	logic [T_W-1:0]   quo_q;
	logic [SEG_W:0]   trial;
	logic [SEG_W:0]   diff;
	logic             ge;

	// One quotient bit per cycle, most significant first.
	always_comb begin
		trial = {rem_q, T_ONE[cnt_q]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(T_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SEG_W-1:0] : trial[SEG_W-1:0];
			quo_q <= {quo_q[T_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

FILE: design/cmrt_mac.sv
// Shared signed multiplier with a registered product, followed by the
// accumulator that rounds and saturates each coordinate. Depends on cmrt_pkg.
module cmrt_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmrt_pkg::mac_ctl_t              ctl,
	input  logic signed [cmrt_pkg::MA_W-1:0] op_a,
	input  logic signed [cmrt_pkg::MB_W-1:0] op_b,
	output logic signed [cmrt_pkg::PROD_W-1:0] prod,
	output cmrt_pkg::mac_res_t              res
);
	import cmrt_pkg::*;

	localparam logic signed [PROD_W-1:0] RND_HALF = 60'sd8388608;
	localparam logic signed [PROD_W-1:0] SAT_MAX  = 60'sd2147483647;
	localparam logic signed [PROD_W-1:0] SAT_MIN  = -60'sd2147483648;

	logic signed [PROD_W-1:0] prod_s1;
	mac_ctl_t                 ctl_s1;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] base;
	logic signed [PROD_W-1:0] sum;
	logic signed [PROD_W-1:0] shr;

	// Product register; the control tag is registered alongside it.
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	// Accumulate the weighted control points of one coordinate.
	always_comb begin
		base = ctl_s1.first ? '0 : acc_q;
		sum  = base + prod_s1;
		shr  = (sum + RND_HALF) >>> 24;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			acc_q <= sum;
		end
	end

	// Round to Q16.16 and clamp to the signed 32-bit range.
	always_comb begin
		res.vld = ctl_s1.vld & ctl_s1.last;
		res.idx = ctl_s1.idx;
		if (shr > SAT_MAX) begin
			res.coord = SAT_MAX[COORD_W-1:0];
		end else if (shr < SAT_MIN) begin
			res.coord = SAT_MIN[COORD_W-1:0];
		end else begin
			res.coord = shr[COORD_W-1:0];
		end
	end

	assign prod = prod_s1;

endmodule
